[rtl/core/rsfc_pkg.sv]
// Shared types, widths and arithmetic helpers for the ray/sphere far clip pipeline.
`default_nettype none

package rsfc_pkg;

   localparam int COORD_W           = 24;
   localparam int DIR_W             = 16;
   localparam int RADIUS_W          = 20;
   localparam int DIR_FRAC_BITS_DEF = 14;

   // center - origin, one product d*dir, and the sum of three products
   localparam int D_W    = COORD_W + 1;
   localparam int PROD_W = D_W + DIR_W;
   localparam int DOT_W  = PROD_W + 2;

   // squares and sums of squares saturate at 2^62
   localparam int              SQ_W   = 63;
   localparam logic [SQ_W-1:0] SQ_CAP = SQ_W'(1) << 62;

   localparam int ROOT_W      = 32;
   localparam int SQRT_STAGES = ROOT_W / 2;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [DIR_W-1:0]   dir_z;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
   } req_type;

   typedef struct packed {
      logic                      hit;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic signed [COORD_W-1:0] point_z;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } coord3_type;

   typedef struct packed {
      logic signed [DIR_W-1:0] x;
      logic signed [DIR_W-1:0] y;
      logic signed [DIR_W-1:0] z;
   } dir3_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_type;

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   // square of a magnitude, capped once the magnitude reaches 2^31
   function automatic logic [SQ_W-1:0] sat_sq(input logic [63:0] mag);
      logic [61:0] p;
      p = mag[30:0] * mag[30:0];
      return (mag[63:31] != '0) ? SQ_CAP : {1'b0, p};
   endfunction

   function automatic logic [SQ_W-1:0] sat_add(input logic [SQ_W-1:0] a,
                                               input logic [SQ_W-1:0] b);
      logic [SQ_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, SQ_CAP}) ? SQ_CAP : s[SQ_W-1:0];
   endfunction

   // one digit of the restoring square root
   function automatic sqrt_type sqrt_step(input sqrt_type a, input logic [63:0] bitv);
      sqrt_type    r;
      logic [63:0] trial;
      trial = a.root + bitv;
      if (a.rem >= trial) begin
         r.rem  = a.rem - trial;
         r.root = (a.root >> 1) + bitv;
      end else begin
         r.rem  = a.rem;
         r.root = a.root >> 1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/rsfc_setup.sv]
// Front stages: offset, dot product, squared lengths and hit test (five stages).
`default_nettype none

module rsfc_setup #(
   parameter int DIR_FRAC_BITS = rsfc_pkg::DIR_FRAC_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   in_valid,
   output logic                                  in_ready,
   input  rsfc_pkg::req_type                     in_data,
   input  wire  [rsfc_pkg::RADIUS_W-1:0]         radius,
   output logic                                  out_valid,
   input  wire                                   out_ready,
   output rsfc_pkg::coord3_type                  out_origin,
   output rsfc_pkg::dir3_type                    out_dir,
   output logic signed [rsfc_pkg::DOT_W-DIR_FRAC_BITS-1:0] out_t,
   output logic                                  out_hit,
   output logic [rsfc_pkg::SQ_W-1:0]             out_diff
);

   localparam int T_W = rsfc_pkg::DOT_W - DIR_FRAC_BITS;

   logic [5:1] v_ff;
   logic [5:0] vld;
   logic [5:1] en;

   assign vld       = {v_ff, in_valid};
   assign en[5]     = out_ready;
   assign en[4]     = !v_ff[4] || en[5];
   assign en[3]     = !v_ff[3] || en[4];
   assign en[2]     = !v_ff[2] || en[3];
   assign en[1]     = !v_ff[1] || en[2];
   assign in_ready  = en[1];
   assign out_valid = v_ff[5];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k < 6; k++) begin
            if (en[k]) v_ff[k] <= vld[k-1];
         end
      end
   end

   // stage 1: d = center - origin
   logic signed [rsfc_pkg::COORD_W-1:0] org_a [3];
   logic signed [rsfc_pkg::COORD_W-1:0] ctr_a [3];
   logic signed [rsfc_pkg::DIR_W-1:0]   dir_a [3];
   logic signed [rsfc_pkg::D_W-1:0]     s1_d_ff [3];
   rsfc_pkg::coord3_type s1_org_ff, s2_org_ff, s3_org_ff, s4_org_ff, s5_org_ff;
   rsfc_pkg::dir3_type   s1_dir_ff, s2_dir_ff, s3_dir_ff, s4_dir_ff, s5_dir_ff;
   logic signed [rsfc_pkg::DIR_W-1:0]   s1_dir_a [3];

   assign org_a[0] = in_data.origin_x;
   assign org_a[1] = in_data.origin_y;
   assign org_a[2] = in_data.origin_z;
   assign ctr_a[0] = in_data.center_x;
   assign ctr_a[1] = in_data.center_y;
   assign ctr_a[2] = in_data.center_z;
   assign dir_a[0] = in_data.dir_x;
   assign dir_a[1] = in_data.dir_y;
   assign dir_a[2] = in_data.dir_z;
   assign s1_dir_a[0] = s1_dir_ff.x;
   assign s1_dir_a[1] = s1_dir_ff.y;
   assign s1_dir_a[2] = s1_dir_ff.z;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         for (int i = 0; i < 3; i++) begin
            s1_d_ff[i] <= rsfc_pkg::D_W'(ctr_a[i]) - rsfc_pkg::D_W'(org_a[i]);
         end
         s1_org_ff <= '{x: org_a[0], y: org_a[1], z: org_a[2]};
         s1_dir_ff <= '{x: dir_a[0], y: dir_a[1], z: dir_a[2]};
      end
   end

   // stage 2: products and squares
   logic signed [rsfc_pkg::PROD_W-1:0] s2_p_ff [3];
   logic [rsfc_pkg::SQ_W-1:0]          s2_sq_ff [3];
   logic [rsfc_pkg::SQ_W-1:0]          s2_r2_ff, s3_r2_ff, s4_r2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            s2_p_ff[i]  <= s1_d_ff[i] * s1_dir_a[i];
            s2_sq_ff[i] <= rsfc_pkg::sat_sq(rsfc_pkg::mag64(64'(s1_d_ff[i])));
         end
         s2_r2_ff  <= rsfc_pkg::sat_sq(64'(radius));
         s2_org_ff <= s1_org_ff;
         s2_dir_ff <= s1_dir_ff;
      end
   end

   // stage 3: dot product and |d|^2
   logic signed [rsfc_pkg::DOT_W-1:0] s3_dot_ff;
   logic [rsfc_pkg::SQ_W-1:0]         s3_dd_ff, s4_dd_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_dot_ff <= rsfc_pkg::DOT_W'(s2_p_ff[0]) + rsfc_pkg::DOT_W'(s2_p_ff[1])
                    + rsfc_pkg::DOT_W'(s2_p_ff[2]);
         s3_dd_ff  <= rsfc_pkg::sat_add(rsfc_pkg::sat_add(s2_sq_ff[0], s2_sq_ff[1]),
                                        s2_sq_ff[2]);
         s3_r2_ff  <= s2_r2_ff;
         s3_org_ff <= s2_org_ff;
         s3_dir_ff <= s2_dir_ff;
      end
   end

   // stage 4: t = floor(dot / 2^frac), t^2
   logic signed [T_W-1:0]     t_c;
   logic signed [T_W-1:0]     s4_t_ff, s5_t_ff;
   logic [rsfc_pkg::SQ_W-1:0] s4_t2_ff;
   logic                      s4_pos_ff;

   assign t_c = s3_dot_ff[rsfc_pkg::DOT_W-1:DIR_FRAC_BITS];

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_t_ff   <= t_c;
         s4_t2_ff  <= rsfc_pkg::sat_sq(rsfc_pkg::mag64(64'(t_c)));
         s4_pos_ff <= !s3_dot_ff[rsfc_pkg::DOT_W-1];
         s4_dd_ff  <= s3_dd_ff;
         s4_r2_ff  <= s3_r2_ff;
         s4_org_ff <= s3_org_ff;
         s4_dir_ff <= s3_dir_ff;
      end
   end

   // stage 5: r^2 + t^2 against |d|^2
   logic [rsfc_pkg::SQ_W-1:0] lhs_c;
   logic [rsfc_pkg::SQ_W-1:0] s5_diff_ff;
   logic                      s5_hit_ff;

   assign lhs_c = rsfc_pkg::sat_add(s4_r2_ff, s4_t2_ff);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_hit_ff  <= s4_pos_ff && (lhs_c >= s4_dd_ff);
         s5_diff_ff <= lhs_c - s4_dd_ff;
         s5_t_ff    <= s4_t_ff;
         s5_org_ff  <= s4_org_ff;
         s5_dir_ff  <= s4_dir_ff;
      end
   end

   assign out_origin = s5_org_ff;
   assign out_dir    = s5_dir_ff;
   assign out_t      = s5_t_ff;
   assign out_hit    = s5_hit_ff;
   assign out_diff   = s5_diff_ff;

endmodule

`default_nettype wire

[rtl/core/rsfc_sqrt.sv]
// Pipelined integer square root, two result bits per stage, with carried sideband.
`default_nettype none

module rsfc_sqrt #(
   parameter int SIDE_W = 1
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              in_valid,
   output logic                             in_ready,
   input  wire  [rsfc_pkg::SQ_W-1:0]        in_value,
   input  wire  [SIDE_W-1:0]                in_side,
   output logic                             out_valid,
   input  wire                              out_ready,
   output logic [rsfc_pkg::ROOT_W-1:0]      out_root,
   output logic [SIDE_W-1:0]                out_side
);

   localparam int NS = rsfc_pkg::SQRT_STAGES;

   logic               vld [NS+1];
   logic               en  [NS+1];
   rsfc_pkg::sqrt_type acc [NS+1];
   logic [SIDE_W-1:0]  side [NS+1];

   assign vld[0]  = in_valid;
   assign acc[0]  = '{rem: 64'(in_value), root: '0};
   assign side[0] = in_side;
   assign en[NS]  = out_ready;
   assign in_ready = en[0];

   for (genvar g = 0; g < NS; g++) begin : g_stage
      localparam logic [63:0] BIT_HI = 64'(1) << (2 * (rsfc_pkg::ROOT_W - 1 - 2 * g));
      localparam logic [63:0] BIT_LO = 64'(1) << (2 * (rsfc_pkg::ROOT_W - 2 - 2 * g));

      rsfc_pkg::sqrt_type nxt_c;
      logic               v_ff;
      rsfc_pkg::sqrt_type acc_ff;
      logic [SIDE_W-1:0]  side_ff;

      assign nxt_c = rsfc_pkg::sqrt_step(rsfc_pkg::sqrt_step(acc[g], BIT_HI), BIT_LO);

      if (g < NS - 1) begin : g_en
         assign en[g+1] = !vld[g+1] || en[g+2];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en[g+1]) begin
            v_ff <= vld[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en[g+1]) begin
            acc_ff  <= nxt_c;
            side_ff <= side[g];
         end
      end

      assign vld[g+1]  = v_ff;
      assign acc[g+1]  = acc_ff;
      assign side[g+1] = side_ff;
   end

   assign en[0]     = en[1];
   assign out_valid = vld[NS];
   assign out_root  = acc[NS].root[rsfc_pkg::ROOT_W-1:0];
   assign out_side  = side[NS];

endmodule

`default_nettype wire

[rtl/core/rsfc_clip.sv]
// Back stages: travel distance, scaled direction, offset from origin and saturation.
`default_nettype none

module rsfc_clip #(
   parameter int DIR_FRAC_BITS = rsfc_pkg::DIR_FRAC_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   in_valid,
   output logic                                  in_ready,
   input  wire                                   in_hit,
   input  wire  signed [rsfc_pkg::DOT_W-DIR_FRAC_BITS-1:0] in_t,
   input  wire  [rsfc_pkg::ROOT_W-1:0]           in_root,
   input  rsfc_pkg::coord3_type                  in_origin,
   input  rsfc_pkg::dir3_type                    in_dir,
   input  wire  [rsfc_pkg::RADIUS_W-1:0]         radius,
   output logic                                  out_valid,
   input  wire                                   out_ready,
   output rsfc_pkg::rsp_type                     out_data
);

   localparam int T_W    = rsfc_pkg::DOT_W - DIR_FRAC_BITS;
   localparam int DIST_W = ((T_W > rsfc_pkg::ROOT_W) ? T_W : rsfc_pkg::ROOT_W) + 2;
   localparam int PR_W   = DIST_W + rsfc_pkg::DIR_W;
   localparam int SH_W   = PR_W - DIR_FRAC_BITS;
   localparam int SUM_W  = SH_W + 1;
   localparam logic signed [SUM_W-1:0] HI = SUM_W'(2 ** (rsfc_pkg::COORD_W - 1) - 1);
   localparam logic signed [SUM_W-1:0] LO = -HI - SUM_W'(1);

   logic [3:1] v_ff;
   logic [3:0] vld;
   logic [3:0] en;

   assign vld       = {v_ff, in_valid};
   assign en[3]     = out_ready;
   assign en[2]     = !v_ff[2] || en[3];
   assign en[1]     = !v_ff[1] || en[2];
   assign en[0]     = en[1];
   assign in_ready  = en[0];
   assign out_valid = v_ff[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k < 4; k++) begin
            if (en[k]) v_ff[k] <= vld[k-1];
         end
      end
   end

   // stage 1: distance along the ray
   logic signed [DIST_W-1:0] c1_dist_ff;
   logic                     c1_hit_ff, c2_hit_ff;
   rsfc_pkg::coord3_type     c1_org_ff, c2_org_ff;
   rsfc_pkg::dir3_type       c1_dir_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         c1_dist_ff <= in_hit ? (DIST_W'(in_t) + DIST_W'({1'b0, in_root}))
                              : DIST_W'({1'b0, radius});
         c1_hit_ff  <= in_hit;
         c1_org_ff  <= in_origin;
         c1_dir_ff  <= in_dir;
      end
   end

   // stage 2: dist * dir
   logic signed [rsfc_pkg::DIR_W-1:0] c1_dir_a [3];
   logic signed [PR_W-1:0]            c2_p_ff [3];

   assign c1_dir_a[0] = c1_dir_ff.x;
   assign c1_dir_a[1] = c1_dir_ff.y;
   assign c1_dir_a[2] = c1_dir_ff.z;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            c2_p_ff[i] <= c1_dist_ff * c1_dir_a[i];
         end
         c2_hit_ff <= c1_hit_ff;
         c2_org_ff <= c1_org_ff;
      end
   end

   // stage 3: floor shift, add origin, clamp
   logic signed [rsfc_pkg::COORD_W-1:0] org_a [3];
   logic signed [SH_W-1:0]              sh_c  [3];
   logic signed [SUM_W-1:0]             sum_c [3];
   logic signed [rsfc_pkg::COORD_W-1:0] pt_c  [3];
   rsfc_pkg::rsp_type                   rsp_ff;

   assign org_a[0] = c2_org_ff.x;
   assign org_a[1] = c2_org_ff.y;
   assign org_a[2] = c2_org_ff.z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sh_c[i]  = c2_p_ff[i][PR_W-1:DIR_FRAC_BITS];
         sum_c[i] = SUM_W'(sh_c[i]) + SUM_W'(org_a[i]);
         if (sum_c[i] > HI) begin
            pt_c[i] = HI[rsfc_pkg::COORD_W-1:0];
         end else if (sum_c[i] < LO) begin
            pt_c[i] = LO[rsfc_pkg::COORD_W-1:0];
         end else begin
            pt_c[i] = sum_c[i][rsfc_pkg::COORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         rsp_ff <= '{hit: c2_hit_ff, point_x: pt_c[0], point_y: pt_c[1], point_z: pt_c[2]};
      end
   end

   assign out_data = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/ray_sphere_far_clip.sv]
// Structure: from an accepted req transaction to its rsp transaction a ray passes
//   5 setup stages, 16 square root stages at two root bits each, and 3 clip stages.
// Throughput: one ray per cycle; every stage holds its own valid bit, so bubbles
//   fill in behind a stalled rsp and req is stalled only when the whole pipe is full.
// Reset: synchronous, active high; clears all stage valid bits and sets the radius to 0.
`default_nettype none

module ray_sphere_far_clip #(
   parameter int DIR_FRAC_BITS = rsfc_pkg::DIR_FRAC_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // ray requests
   input  wire                          req_valid,
   output logic                         req_stall,
   input  rsfc_pkg::req_type            req_data,
   // clipped points
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output rsfc_pkg::rsp_type            rsp_data,
   // radius register
   input  wire                          csr_valid,
   output logic                         csr_ready,
   input  wire  [rsfc_pkg::RADIUS_W-1:0] csr_data
);

   localparam int T_W = rsfc_pkg::DOT_W - DIR_FRAC_BITS;

   // Sideband that rides through the square root stages next to the radicand.
   typedef struct packed {
      logic                  hit;
      logic signed [T_W-1:0] t;
      rsfc_pkg::coord3_type  origin;
      rsfc_pkg::dir3_type    dir;
   } side_type;

   localparam int SIDE_W = $bits(side_type);

   // Radius register. The user must write it only while the pipe is empty, so
   // every stage reads it directly; the block does not enforce this.
   logic [rsfc_pkg::RADIUS_W-1:0] radius_ff;
   logic [rsfc_pkg::RADIUS_W-1:0] radius_in;

   assign csr_ready = 1'b1;
   assign radius_in = (csr_valid && csr_ready) ? csr_data : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else begin
         radius_ff <= radius_in;
      end
   end

   // Front: d, dot(d, dir), |d|^2, t^2 and the hit test.
   logic                          setup_in_ready;
   logic                          setup_valid;
   logic                          sqrt_in_ready;
   rsfc_pkg::coord3_type          setup_origin;
   rsfc_pkg::dir3_type            setup_dir;
   logic signed [T_W-1:0]         setup_t;
   logic                          setup_hit;
   logic [rsfc_pkg::SQ_W-1:0]     setup_diff;

   assign req_stall = !setup_in_ready;

   rsfc_setup #(
      .DIR_FRAC_BITS(DIR_FRAC_BITS)
   ) u_setup (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (setup_in_ready),
      .in_data    (req_data),
      .radius     (radius_ff),
      .out_valid  (setup_valid),
      .out_ready  (sqrt_in_ready),
      .out_origin (setup_origin),
      .out_dir    (setup_dir),
      .out_t      (setup_t),
      .out_hit    (setup_hit),
      .out_diff   (setup_diff)
   );

   // Middle: floor_sqrt(r^2 + t^2 - |d|^2). On a miss the root is computed
   // anyway and ignored downstream.
   side_type                       side_in;
   side_type                       side_out;
   logic [SIDE_W-1:0]              side_out_bits;
   logic                           sqrt_valid;
   logic                           clip_in_ready;
   logic [rsfc_pkg::ROOT_W-1:0]    sqrt_root;

   assign side_in  = '{hit: setup_hit, t: setup_t, origin: setup_origin, dir: setup_dir};
   assign side_out = side_type'(side_out_bits);

   rsfc_sqrt #(
      .SIDE_W(SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (setup_valid),
      .in_ready  (sqrt_in_ready),
      .in_value  (setup_diff),
      .in_side   (SIDE_W'(side_in)),
      .out_valid (sqrt_valid),
      .out_ready (clip_in_ready),
      .out_root  (sqrt_root),
      .out_side  (side_out_bits)
   );

   // Back: hit picks t + s, miss picks the radius; scale the direction,
   // add the origin and clamp to the coordinate range.
   rsfc_clip #(
      .DIR_FRAC_BITS(DIR_FRAC_BITS)
   ) u_clip (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sqrt_valid),
      .in_ready  (clip_in_ready),
      .in_hit    (side_out.hit),
      .in_t      (side_out.t),
      .in_root   (sqrt_root),
      .in_origin (side_out.origin),
      .in_dir    (side_out.dir),
      .radius    (radius_ff),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .out_data  (rsp_data)
   );

endmodule

`default_nettype wire
